[rtl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Constants and status codes shared by the page table walker files.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int MEM_WORDS_LOG2 = 14;

	localparam int FUNC_W  = 1;
	localparam int WIDX_W  = 14;
	localparam int WORD_W  = 64;
	localparam int VA_W    = 48;
	localparam int PPN_W   = 40;
	localparam int PA_W    = 52;
	localparam int STAT_W  = 3;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_WALK  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_HIT_4K      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_HIT_2M      = 3'd1;
	localparam logic [STAT_W-1:0] STAT_HIT_1G      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FAULT_PML4  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_WRITE_DONE  = 3'd7;

	localparam int BIT_P  = 0;
	localparam int BIT_RW = 1;
	localparam int BIT_US = 2;
	localparam int BIT_PS = 7;
	localparam int BIT_NX = 63;

	typedef logic [MEM_WORDS_LOG2-1:0] mem_idx_t;
	typedef logic [WORD_W-1:0]         word_t;
	typedef logic [PA_W-1:0]           paddr_t;

endpackage

[rtl/ptw_if.sv]
// ----------------------------------------------------------------------------
// ptw channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptw_req_if;
	import ptw_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [WIDX_W-1:0]   word_index;
	logic [WORD_W-1:0]   word_data;
	logic [VA_W-1:0]     vaddr;
	logic                acc_write;
	logic                acc_user;
	logic                acc_ifetch;
	modport source (output valid, func, word_index, word_data, vaddr,
		acc_write, acc_user, acc_ifetch, input ready);
	modport sink (input valid, func, word_index, word_data, vaddr,
		acc_write, acc_user, acc_ifetch, output ready);
endinterface

interface ptw_rsp_if;
	import ptw_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [PA_W-1:0]     entry_addr;
	logic [WORD_W-1:0]   entry_value;
	modport source (output valid, status, entry_addr, entry_value, input ready);
	modport sink (input valid, status, entry_addr, entry_value, output ready);
endinterface

interface ptw_cfg_if;
	import ptw_pkg::*;
	logic                valid;
	logic                ready;
	logic [PPN_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/page_table_walker.sv]
// ----------------------------------------------------------------------------
// page_table_walker
// Four-level x86-64 page table walk over an internal table memory.
// ----------------------------------------------------------------------------
// Sequence: a walk reads one table level at a time (1 to 4 reads) after
// acceptance; a table write passes through ST_WDONE and reports done once the
// output slot is free. One item at a time: a new request is accepted only in
// idle, and a walk is paced by dependent registered reads of the table memory.
// Reset clears control state and root_page; table memory is undefined
// until written.
module page_table_walker (
	input  logic        clk,
	input  logic        arst_n,
	ptw_req_if.sink     req,
	ptw_rsp_if.source   rsp,
	ptw_cfg_if.sink     cfg
);
	import ptw_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_WDONE = 2'd2;

	word_t               mem [2**MEM_WORDS_LOG2];
	word_t               rd_data_q;
	logic                rd_en;
	mem_idx_t            rd_idx;

	logic [1:0]          state_q;
	logic [1:0]          lvl_q;
	logic [PPN_W-1:0]    root_q;
	logic [VA_W-1:0]     va_q;
	logic                wr_q, us_q, fx_q;
	paddr_t              addr_q;
	paddr_t              next_addr;
	logic [1:0]          next_lvl;

	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	paddr_t              out_addr_q;
	word_t               out_value_q;

	logic                req_fire;
	logic                slot_free;
	logic                grant;
	logic                leaf;
	logic                finish;
	logic [STAT_W-1:0]   fin_status;

	function automatic logic [8:0] va_slice(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [8:0] r;
		unique case (lvl)
			2'd0: r = va[47:39];
			2'd1: r = va[38:30];
			2'd2: r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	assign grant = rd_data_q[BIT_P] && (!wr_q || rd_data_q[BIT_RW])
		&& (!us_q || rd_data_q[BIT_US]) && (!fx_q || !rd_data_q[BIT_NX]);
	assign leaf  = (lvl_q == 2'd3) || (rd_data_q[BIT_PS] && (lvl_q == 2'd1 || lvl_q == 2'd2));
	assign next_lvl  = lvl_q + 2'd1;
	assign next_addr = {rd_data_q[51:12], va_slice(va_q, next_lvl), 3'b000};

	always_comb begin
		finish     = 1'b0;
		fin_status = STAT_WRITE_DONE;
		rd_en      = 1'b0;
		rd_idx     = next_addr[MEM_WORDS_LOG2+2:3];
		if (state_q == ST_WALK) begin
			if (!grant) begin
				finish     = slot_free;
				fin_status = STAT_FAULT_PML4 + {1'b0, lvl_q};
			end else if (leaf) begin
				finish = slot_free;
				unique case (lvl_q)
					2'd1: fin_status = STAT_HIT_1G;
					2'd2: fin_status = STAT_HIT_2M;
					default: fin_status = STAT_HIT_4K;
				endcase
			end else begin
				rd_en = 1'b1;
			end
		end else if (state_q == ST_WDONE) begin
			finish = slot_free;
		end else if (req_fire && req.func == FUNC_WALK) begin
			rd_en  = 1'b1;
			rd_idx = mem_idx_t'({root_q, va_slice(req.vaddr, 2'd0)});
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.func == FUNC_WRITE) begin
			mem[mem_idx_t'(req.word_index)] <= req.word_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= 2'd0;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				root_q <= cfg.data;
			end
			out_valid_q <= finish || (out_valid_q && !rsp.ready);
			if (finish) begin
				state_q <= ST_IDLE;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= (req.func == FUNC_WALK) ? ST_WALK : ST_WDONE;
						lvl_q   <= 2'd0;
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						lvl_q <= next_lvl;
					end
				end
				ST_WDONE: ;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			va_q   <= req.vaddr;
			wr_q   <= req.acc_write;
			us_q   <= req.acc_user;
			fx_q   <= req.acc_ifetch;
			addr_q <= {root_q, va_slice(req.vaddr, 2'd0), 3'b000};
		end else if (rd_en) begin
			addr_q <= next_addr;
		end
		if (finish) begin
			out_status_q <= fin_status;
			out_addr_q   <= (state_q == ST_WDONE) ? '0 : addr_q;
			out_value_q  <= (state_q == ST_WDONE) ? '0 : rd_data_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_addr  = out_addr_q;
	assign rsp.entry_value = out_value_q;

endmodule
